// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in the same cycle as its antecedent.
`define SSTM_ASSERT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sstm assertion failed");

// Property whose consequent must hold in the cycle after its antecedent.
`define SSTM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sstm assertion failed");

`endif

// ----- hw/rtl/sstm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer manager package
// Shared types and constants for the front end, command queue and engine.
// ----------------------------------------------------------------------------
package sstm_pkg;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_ADD    = 2'd1,
    ACT_CANCEL = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    KIND_ADD_ACK    = 2'd0,
    KIND_EXPIRY     = 2'd1,
    KIND_SUMMARY    = 2'd2,
    KIND_CANCEL_ACK = 2'd3
  } kind_e;

  localparam int unsigned TIMEOUT_W = 32;
  localparam int unsigned ID_W      = 8;
  localparam int unsigned CHAN_W    = 3;
  localparam int unsigned HANDLE_W  = 4;

  localparam logic [ID_W-1:0] SWITCH_ID_RESET = 8'd116;
  localparam int unsigned     QUEUE_DEPTH     = 2;

  typedef struct packed {
    action_e               op;
    logic [TIMEOUT_W-1:0]  timeout;
    logic [ID_W-1:0]       id;
    logic [CHAN_W-1:0]     chan;
    logic [HANDLE_W-1:0]   handle;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ----- hw/rtl/sorted_software_timer_manager.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted software timer manager
// Pool of one-shot timers kept in timeout order, driven by tick, add and
// cancel commands on a stream input.
// ----------------------------------------------------------------------------
// Commands enter on the s_axis channel, one beat per command, and results
// leave on the m_axis channel, one beat per result with tlast on the final
// result of a command. The switch timer id is written through cfg_we_i and
// cfg_wdata_i, by the user only while the block is idle; the block itself
// does not enforce this. A two-entry queue takes commands while the engine
// works, so the input keeps accepting beats, until the queue is full, while
// a result waits on a stalled output. An add walks the sorted list past every
// entry with a smaller or equal timeout, and a cancel walks the entries ahead
// of its slot. A tick decrements every timer, then gives one expiry per
// expired timer other than the switch timer, and then the summary; a tick on
// an empty pool gives no result. The walk over the sorted list is sequential;
// one command is in the engine at a time.
// Reset empties the pool and restores the switch id to 116. There is no
// clearing pass. When the receiver stalls, the result is held in the output
// register and the engine waits before producing the next one.
module sorted_software_timer_manager #(
  parameter int unsigned TIMER_SLOTS = 16,
  parameter int unsigned CHANNELS    = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // timeout_ticks[31:0], timer_id[39:32], notify_channel[42:40],
  // cancel_handle[46:43], zero[47]
  input  logic [47:0] s_axis_tdata,
  // action[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // slot[3:0], expired_id[11:4], expired_channel[14:12], switch_request[15],
  // error[16], zero[23:17]
  output logic [23:0] m_axis_tdata,
  // kind[1:0]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);

  sstm_pkg::queue_status_t        qstat;
  sstm_pkg::cmd_t                 push_cmd, head_cmd;
  sstm_pkg::kind_e                kind;
  logic                           push, pop;
  logic [sstm_pkg::ID_W-1:0]      switch_id_q, res_id;
  logic [3:0]                     res_slot;
  logic [sstm_pkg::CHAN_W-1:0]    res_chan;
  logic                           res_switch, res_error;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      switch_id_q <= sstm_pkg::SWITCH_ID_RESET;
    end else if (cfg_we_i) begin
      switch_id_q <= cfg_wdata_i;
    end
  end

  sstm_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .status_i       (qstat),
    .push_o         (push),
    .cmd_o          (push_cmd)
  );

  sstm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .status_o(qstat)
  );

  sstm_engine #(
    .TIMER_SLOTS(TIMER_SLOTS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!qstat.empty),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .switch_id_i (switch_id_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (kind),
    .out_slot_o  (res_slot),
    .out_id_o    (res_id),
    .out_chan_o  (res_chan),
    .out_switch_o(res_switch),
    .out_error_o (res_error),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tuser = kind;
  assign m_axis_tdata = {7'b0, res_error, res_switch, res_chan, res_id, res_slot};

endmodule

// ----- hw/rtl/sstm_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer manager front end
// Accepts input beats, drops unused actions and normalizes the command fields.
// ----------------------------------------------------------------------------
module sstm_front #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [47:0]          s_axis_tdata_i,
  input  logic [1:0]           s_axis_tuser_i,
  input  sstm_pkg::queue_status_t status_i,
  output logic                 push_o,
  output sstm_pkg::cmd_t       cmd_o
);

  function automatic logic [sstm_pkg::CHAN_W-1:0] chan_mod(
    input logic [sstm_pkg::CHAN_W-1:0] v
  );
    logic [4:0] r;
    r = 5'(v);
    for (int i = 0; i < 8; i++) begin
      if (r >= 5'(CHANNELS)) begin
        r = r - 5'(CHANNELS);
      end
    end
    return r[sstm_pkg::CHAN_W-1:0];
  endfunction

  logic [sstm_pkg::TIMEOUT_W-1:0] timeout;
  logic                           known;

  assign timeout = s_axis_tdata_i[31:0];
  assign known   = (s_axis_tuser_i == sstm_pkg::ACT_TICK) ||
                   (s_axis_tuser_i == sstm_pkg::ACT_ADD) ||
                   (s_axis_tuser_i == sstm_pkg::ACT_CANCEL);

  assign s_axis_tready_o = !status_i.full;
  assign push_o          = s_axis_tvalid_i && !status_i.full && known;

  always_comb begin
    cmd_o.op      = sstm_pkg::action_e'(s_axis_tuser_i);
    cmd_o.timeout = (timeout == '0) ? 32'd1 : timeout;
    cmd_o.id      = s_axis_tdata_i[39:32];
    cmd_o.chan    = chan_mod(s_axis_tdata_i[42:40]);
    cmd_o.handle  = s_axis_tdata_i[46:43];
  end

endmodule

// ----- hw/rtl/sstm_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer manager command queue
// Short register queue that decouples the front end from the engine.
// ----------------------------------------------------------------------------
module sstm_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  sstm_pkg::cmd_t          cmd_i,
  input  logic                    pop_i,
  output sstm_pkg::cmd_t          cmd_o,
  output sstm_pkg::queue_status_t status_o
);

  localparam int unsigned PW = $clog2(sstm_pkg::QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(sstm_pkg::QUEUE_DEPTH + 1);

  sstm_pkg::cmd_t mem_q [sstm_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]  cnt_q, cnt_d;

  assign status_o.full  = (cnt_q == CW'(sstm_pkg::QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign cmd_o          = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(sstm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(sstm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

// ----- hw/rtl/sstm_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer manager engine
// Keeps the timers as a list sorted by remaining ticks and runs each command.
// ----------------------------------------------------------------------------
module sstm_engine #(
  parameter int unsigned TIMER_SLOTS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  input  sstm_pkg::cmd_t                cmd_i,
  output logic                          pop_o,
  input  logic [sstm_pkg::ID_W-1:0]     switch_id_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output sstm_pkg::kind_e               out_kind_o,
  output logic [3:0]                    out_slot_o,
  output logic [sstm_pkg::ID_W-1:0]     out_id_o,
  output logic [sstm_pkg::CHAN_W-1:0]   out_chan_o,
  output logic                          out_switch_o,
  output logic                          out_error_o,
  output logic                          out_last_o
);

  localparam int unsigned SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int unsigned CW = $clog2(TIMER_SLOTS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ADD_SCAN,
    ST_CAN_SCAN,
    ST_TICK_EXP
  } state_e;

  state_e                         state_q, state_d;
  sstm_pkg::cmd_t                 cur_q, cur_d;
  logic [CW-1:0]                  cnt_q, cnt_d, idx_q, idx_d;
  logic [SW-1:0]                  new_slot_q, new_slot_d;
  logic                           sw_q, sw_d;
  logic [TIMER_SLOTS-1:0]         valid_q, valid_d;

  logic                           out_valid_q, out_valid_d, out_switch_q, out_switch_d;
  logic                           out_error_q, out_error_d, out_last_q, out_last_d;
  sstm_pkg::kind_e                out_kind_q, out_kind_d;
  logic [3:0]                     out_slot_q, out_slot_d;
  logic [sstm_pkg::ID_W-1:0]      out_id_q, out_id_d;
  logic [sstm_pkg::CHAN_W-1:0]    out_chan_q, out_chan_d;

  logic [SW-1:0]                  pos_slot_q [TIMER_SLOTS];
  logic [sstm_pkg::TIMEOUT_W-1:0] pos_rem_q  [TIMER_SLOTS];
  logic [sstm_pkg::ID_W-1:0]      pos_id_q   [TIMER_SLOTS];
  logic [sstm_pkg::CHAN_W-1:0]    pos_chan_q [TIMER_SLOTS];

  logic [SW-1:0]                  idx_s, free_slot, h_idx, del_pos;
  logic [sstm_pkg::TIMEOUT_W-1:0] rd_rem;
  logic [SW-1:0]                  rd_slot;
  logic                           out_free, at_end, pool_full, h_ok, head_exp;
  logic                           ins_en, del_en, dec_en;

  assign idx_s     = idx_q[SW-1:0];
  assign rd_rem    = pos_rem_q[idx_s];
  assign rd_slot   = pos_slot_q[idx_s];
  assign at_end    = (idx_q == cnt_q);
  assign out_free  = !out_valid_q || out_ready_i;
  assign pool_full = &valid_q;
  assign h_idx     = SW'(cur_q.handle);
  assign h_ok      = (32'(cur_q.handle) < 32'(TIMER_SLOTS)) && valid_q[h_idx];
  assign head_exp  = (cnt_q != '0) && (pos_rem_q[0] == '0);

  always_comb begin
    free_slot = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_slot = SW'(i);
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    new_slot_d   = new_slot_q;
    sw_d         = sw_q;
    valid_d      = valid_q;
    pop_o        = 1'b0;
    ins_en       = 1'b0;
    del_en       = 1'b0;
    del_pos      = '0;
    dec_en       = 1'b0;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_kind_d   = out_kind_q;
    out_slot_d   = out_slot_q;
    out_id_d     = out_id_q;
    out_chan_d   = out_chan_q;
    out_switch_d = out_switch_q;
    out_error_d  = out_error_q;
    out_last_d   = out_last_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          pop_o   = 1'b1;
          cur_d   = cmd_i;
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        idx_d = '0;
        case (cur_q.op)
          sstm_pkg::ACT_ADD: begin
            if (!pool_full) begin
              new_slot_d = free_slot;
              state_d    = ST_ADD_SCAN;
            end else if (out_free) begin
              out_valid_d = 1'b1;
              out_kind_d  = sstm_pkg::KIND_ADD_ACK;
              out_slot_d  = '0;
              out_id_d    = '0;
              out_chan_d  = '0;
              out_switch_d = 1'b0;
              out_error_d = 1'b1;
              out_last_d  = 1'b1;
              state_d     = ST_IDLE;
            end
          end
          sstm_pkg::ACT_CANCEL: begin
            if (h_ok) begin
              state_d = ST_CAN_SCAN;
            end else if (out_free) begin
              out_valid_d = 1'b1;
              out_kind_d  = sstm_pkg::KIND_CANCEL_ACK;
              out_slot_d  = cur_q.handle;
              out_id_d    = '0;
              out_chan_d  = '0;
              out_switch_d = 1'b0;
              out_error_d = 1'b1;
              out_last_d  = 1'b1;
              state_d     = ST_IDLE;
            end
          end
          sstm_pkg::ACT_TICK: begin
            if (cnt_q == '0) begin
              state_d = ST_IDLE;
            end else begin
              dec_en  = 1'b1;
              sw_d    = 1'b0;
              state_d = ST_TICK_EXP;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_ADD_SCAN: begin
        if (at_end || (rd_rem > cur_q.timeout)) begin
          if (out_free) begin
            ins_en              = 1'b1;
            valid_d[new_slot_q] = 1'b1;
            cnt_d               = cnt_q + 1'b1;
            out_valid_d         = 1'b1;
            out_kind_d          = sstm_pkg::KIND_ADD_ACK;
            out_slot_d          = 4'(new_slot_q);
            out_id_d            = '0;
            out_chan_d          = '0;
            out_switch_d        = 1'b0;
            out_error_d         = 1'b0;
            out_last_d          = 1'b1;
            state_d             = ST_IDLE;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_CAN_SCAN: begin
        if (rd_slot == h_idx) begin
          if (out_free) begin
            del_en         = 1'b1;
            del_pos        = idx_s;
            valid_d[h_idx] = 1'b0;
            cnt_d          = cnt_q - 1'b1;
            out_valid_d    = 1'b1;
            out_kind_d     = sstm_pkg::KIND_CANCEL_ACK;
            out_slot_d     = cur_q.handle;
            out_id_d       = '0;
            out_chan_d     = '0;
            out_switch_d   = 1'b0;
            out_error_d    = 1'b0;
            out_last_d     = 1'b1;
            state_d        = ST_IDLE;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_TICK_EXP: begin
        if (head_exp) begin
          if (pos_id_q[0] == switch_id_i) begin
            sw_d                  = 1'b1;
            del_en                = 1'b1;
            valid_d[pos_slot_q[0]] = 1'b0;
            cnt_d                 = cnt_q - 1'b1;
          end else if (out_free) begin
            del_en                = 1'b1;
            valid_d[pos_slot_q[0]] = 1'b0;
            cnt_d                 = cnt_q - 1'b1;
            out_valid_d           = 1'b1;
            out_kind_d            = sstm_pkg::KIND_EXPIRY;
            out_slot_d            = 4'(pos_slot_q[0]);
            out_id_d              = pos_id_q[0];
            out_chan_d            = pos_chan_q[0];
            out_switch_d          = 1'b0;
            out_error_d           = 1'b0;
            out_last_d            = 1'b0;
          end
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_kind_d   = sstm_pkg::KIND_SUMMARY;
          out_slot_d   = '0;
          out_id_d     = '0;
          out_chan_d   = '0;
          out_switch_d = sw_q;
          out_error_d  = 1'b0;
          out_last_d   = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cur_q        <= '0;
      cnt_q        <= '0;
      idx_q        <= '0;
      new_slot_q   <= '0;
      sw_q         <= 1'b0;
      valid_q      <= '0;
      out_valid_q  <= 1'b0;
      out_kind_q   <= sstm_pkg::KIND_ADD_ACK;
      out_slot_q   <= '0;
      out_id_q     <= '0;
      out_chan_q   <= '0;
      out_switch_q <= 1'b0;
      out_error_q  <= 1'b0;
      out_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      cur_q        <= cur_d;
      cnt_q        <= cnt_d;
      idx_q        <= idx_d;
      new_slot_q   <= new_slot_d;
      sw_q         <= sw_d;
      valid_q      <= valid_d;
      out_valid_q  <= out_valid_d;
      out_kind_q   <= out_kind_d;
      out_slot_q   <= out_slot_d;
      out_id_q     <= out_id_d;
      out_chan_q   <= out_chan_d;
      out_switch_q <= out_switch_d;
      out_error_q  <= out_error_d;
      out_last_q   <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int p = 0; p < TIMER_SLOTS; p++) begin
      int unsigned pm;
      int unsigned pp;
      pm = (p == 0) ? 0 : p - 1;
      pp = (p == TIMER_SLOTS - 1) ? p : p + 1;
      if (ins_en) begin
        if (CW'(p) == idx_q) begin
          pos_slot_q[p] <= new_slot_q;
          pos_rem_q[p]  <= cur_q.timeout;
          pos_id_q[p]   <= cur_q.id;
          pos_chan_q[p] <= cur_q.chan;
        end else if (CW'(p) > idx_q) begin
          pos_slot_q[p] <= pos_slot_q[pm];
          pos_rem_q[p]  <= pos_rem_q[pm];
          pos_id_q[p]   <= pos_id_q[pm];
          pos_chan_q[p] <= pos_chan_q[pm];
        end
      end else if (del_en) begin
        if ((SW'(p) >= del_pos) && (p < TIMER_SLOTS - 1)) begin
          pos_slot_q[p] <= pos_slot_q[pp];
          pos_rem_q[p]  <= pos_rem_q[pp];
          pos_id_q[p]   <= pos_id_q[pp];
          pos_chan_q[p] <= pos_chan_q[pp];
        end
      end else if (dec_en && (pos_rem_q[p] != '0)) begin
        pos_rem_q[p] <= pos_rem_q[p] - 1'b1;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_kind_o   = out_kind_q;
  assign out_slot_o   = out_slot_q;
  assign out_id_o     = out_id_q;
  assign out_chan_o   = out_chan_q;
  assign out_switch_o = out_switch_q;
  assign out_error_o  = out_error_q;
  assign out_last_o   = out_last_q;

endmodule

// ----- hw/rtl/sstm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer manager checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sstm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  `SSTM_ASSERT_NEXT(a_hold_valid, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `SSTM_ASSERT(a_add_last, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser == sstm_pkg::KIND_ADD_ACK), m_axis_tlast && !m_axis_tdata[15])
  `SSTM_ASSERT(a_expiry_not_last, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser == sstm_pkg::KIND_EXPIRY), !m_axis_tlast && !m_axis_tdata[16])
  `SSTM_ASSERT(a_summary_last, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser == sstm_pkg::KIND_SUMMARY), m_axis_tlast && (m_axis_tdata[14:0] == 15'd0) && !m_axis_tdata[16])
  `SSTM_ASSERT(a_cancel_last, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser == sstm_pkg::KIND_CANCEL_ACK), m_axis_tlast && !m_axis_tdata[15])

endmodule

bind sorted_software_timer_manager sstm_checker u_checker (.*);

// ----- verif/timer_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer manager result checker
// Watches the command and result streams, keeps a shadow timer pool, and
// compares every result beat field by field with the predicted one.
// ----------------------------------------------------------------------------
module timer_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int SLOTS = 16;

  typedef struct packed {
    sstm_pkg::kind_e kind;
    logic [3:0]      slot;
    logic [7:0]      id;
    logic [2:0]      chan;
    logic            sw;
    logic            err;
    logic            last;
  } timer_result_t;

  timer_result_t expected_results[$];
  logic [31:0]   remaining[SLOTS];
  logic [7:0]    slot_ids[SLOTS];
  logic [2:0]    slot_chans[SLOTS];
  logic          slot_busy[SLOTS];
  int            order_q[$];
  logic [7:0]    switch_id;
  int            fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_results.size();

  function automatic timer_result_t make_result(sstm_pkg::kind_e k, logic [3:0] s,
                                                logic [7:0] i, logic [2:0] c,
                                                logic sw, logic e, logic l);
    timer_result_t r;
    r.kind = k; r.slot = s; r.id = i; r.chan = c; r.sw = sw; r.err = e; r.last = l;
    return r;
  endfunction

  task automatic predict_command(logic [1:0] op, logic [47:0] d);
    logic [31:0] t;
    int          s;
    int          pos;
    int          h;
    logic        sw;
    int          kept[$];
    if (op == sstm_pkg::ACT_ADD) begin
      t = d[31:0];
      if (t == 0) t = 1;
      s = -1;
      for (int k = SLOTS - 1; k >= 0; k--) if (!slot_busy[k]) s = k;
      if (s < 0) begin
        expected_results.push_back(make_result(sstm_pkg::KIND_ADD_ACK, 0, 0, 0, 0, 1, 1));
      end else begin
        remaining[s] = t; slot_ids[s] = d[39:32]; slot_chans[s] = d[42:40];
        slot_busy[s] = 1;
        pos = 0;
        while (pos < order_q.size() && remaining[order_q[pos]] <= t) pos++;
        order_q.insert(pos, s);
        expected_results.push_back(make_result(sstm_pkg::KIND_ADD_ACK, s, 0, 0, 0, 0, 1));
      end
    end else if (op == sstm_pkg::ACT_CANCEL) begin
      h = d[46:43];
      if (!slot_busy[h]) begin
        expected_results.push_back(
          make_result(sstm_pkg::KIND_CANCEL_ACK, h, 0, 0, 0, 1, 1));
      end else begin
        slot_busy[h] = 0; remaining[h] = 0;
        foreach (order_q[k]) if (order_q[k] == h) kept.push_back(k);
        order_q.delete(kept[0]);
        expected_results.push_back(
          make_result(sstm_pkg::KIND_CANCEL_ACK, h, 0, 0, 0, 0, 1));
      end
    end else if (op == sstm_pkg::ACT_TICK && order_q.size() > 0) begin
      sw = 0;
      foreach (order_q[k]) if (remaining[order_q[k]] > 0) remaining[order_q[k]]--;
      foreach (order_q[k]) begin
        s = order_q[k];
        if (remaining[s] == 0) begin
          if (slot_ids[s] == switch_id) sw = 1;
          else expected_results.push_back(
                 make_result(sstm_pkg::KIND_EXPIRY, s, slot_ids[s], slot_chans[s], 0, 0, 0));
          slot_busy[s] = 0;
        end else begin
          kept.push_back(s);
        end
      end
      order_q = kept;
      expected_results.push_back(make_result(sstm_pkg::KIND_SUMMARY, 0, 0, 0, sw, 0, 1));
    end
  endtask

  task automatic compare_result();
    timer_result_t e;
    if (expected_results.size() == 0) begin
      $error("result beat with nothing expected: kind %0d", m_axis_tuser);
      fails++;
      return;
    end
    e = expected_results.pop_front();
    if (m_axis_tuser !== e.kind) begin
      $error("kind: expected %0d, actual %0d", e.kind, m_axis_tuser); fails++;
    end
    if (m_axis_tdata[3:0] !== e.slot) begin
      $error("slot: expected %0d, actual %0d", e.slot, m_axis_tdata[3:0]); fails++;
    end
    if (m_axis_tdata[11:4] !== e.id) begin
      $error("expired_id: expected %0d, actual %0d", e.id, m_axis_tdata[11:4]); fails++;
    end
    if (m_axis_tdata[14:12] !== e.chan) begin
      $error("expired_channel: expected %0d, actual %0d", e.chan, m_axis_tdata[14:12]);
      fails++;
    end
    if (m_axis_tdata[15] !== e.sw) begin
      $error("switch_request: expected %0d, actual %0d", e.sw, m_axis_tdata[15]); fails++;
    end
    if (m_axis_tdata[16] !== e.err) begin
      $error("error: expected %0d, actual %0d", e.err, m_axis_tdata[16]); fails++;
    end
    if (m_axis_tlast !== e.last) begin
      $error("last: expected %0d, actual %0d", e.last, m_axis_tlast); fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_results.delete();
      order_q.delete();
      for (int k = 0; k < SLOTS; k++) begin
        remaining[k] = 0; slot_busy[k] = 0; slot_ids[k] = 0; slot_chans[k] = 0;
      end
      switch_id = sstm_pkg::SWITCH_ID_RESET;
      fails = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) compare_result();
      if (cfg_we_i) switch_id = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) predict_command(s_axis_tuser, s_axis_tdata);
    end
  end

endmodule

// ----- verif/sorted_software_timer_manager_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer manager testbench
// Drives directed and random tick, add, cancel and unused-action commands
// with bursty input and a stalling receiver, changes the switch id between
// phases, and lets the checker grade every result beat.
// ----------------------------------------------------------------------------
module sorted_software_timer_manager_tb;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we_i = 0;
  logic [7:0]  cfg_wdata_i = '0;
  int          fail_count;
  int          pending;
  int          hold_off = 0;
  logic [7:0]  id_pick;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  sorted_software_timer_manager u_top (.*);

  timer_result_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_we_i, .cfg_wdata_i, .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic send_cmd(sstm_pkg::action_e op, logic [31:0] t, logic [7:0] i,
                          logic [2:0] c, logic [3:0] h);
    s_axis_tvalid <= 1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {1'b0, h, c, i, t};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic pause_input();
    int gap;
    gap = $urandom_range(1, 6);
    s_axis_tvalid <= 0;
    repeat (gap) @(posedge clk_i);
  endtask

  task automatic write_switch_id(logic [7:0] v);
    s_axis_tvalid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    cfg_we_i    <= 1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic random_phase(int count, logic [7:0] sw);
    int r;
    int burst;
    logic [31:0] t;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        if ($urandom_range(0, 2) == 0) pause_input();
        burst = $urandom_range(1, 12);
      end
      burst--;
      r = $urandom_range(0, 99);
      t = ($urandom_range(0, 19) == 0) ? $urandom() : $urandom_range(0, 6);
      id_pick = ($urandom_range(0, 4) == 0) ? sw : 8'($urandom());
      if (r < 40) send_cmd(sstm_pkg::ACT_TICK, $urandom(), $urandom(), $urandom(),
                           $urandom());
      else if (r < 80) send_cmd(sstm_pkg::ACT_ADD, t, id_pick, $urandom(), $urandom());
      else if (r < 97) send_cmd(sstm_pkg::ACT_CANCEL, $urandom(), $urandom(), $urandom(),
                                $urandom());
      else send_cmd(sstm_pkg::action_e'(2'd3), $urandom(), $urandom(), $urandom(),
                    $urandom());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send_cmd(sstm_pkg::ACT_TICK, 0, 0, 0, 0);
    send_cmd(sstm_pkg::ACT_CANCEL, 0, 0, 0, 4'hF);
    send_cmd(sstm_pkg::ACT_ADD, 0, 8'h00, 3'd0, 0);
    send_cmd(sstm_pkg::ACT_ADD, 32'hFFFF_FFFF, 8'hFF, 3'd7, 4'hF);
    send_cmd(sstm_pkg::ACT_ADD, 2, sstm_pkg::SWITCH_ID_RESET, 3'd5, 0);
    send_cmd(sstm_pkg::ACT_ADD, 2, 8'hA5, 3'd2, 0);
    send_cmd(sstm_pkg::ACT_ADD, 1, 8'h5A, 3'd1, 0);
    send_cmd(sstm_pkg::action_e'(2'd3), 32'hFFFF_FFFF, 8'hFF, 3'd7, 4'hF);
    send_cmd(sstm_pkg::ACT_TICK, 0, 0, 0, 0);
    send_cmd(sstm_pkg::ACT_TICK, 0, 0, 0, 0);
    send_cmd(sstm_pkg::ACT_CANCEL, 0, 0, 0, 4'd1);
    send_cmd(sstm_pkg::ACT_CANCEL, 0, 0, 0, 4'd1);
    hold_off = 300;
    for (int k = 0; k < 18; k++) send_cmd(sstm_pkg::ACT_ADD, k % 3 + 1, 8'(k), 3'(k), 0);
    send_cmd(sstm_pkg::ACT_TICK, 0, 0, 0, 0);
    send_cmd(sstm_pkg::ACT_TICK, 0, 0, 0, 0);
    send_cmd(sstm_pkg::ACT_TICK, 0, 0, 0, 0);
    random_phase(80, sstm_pkg::SWITCH_ID_RESET);
    write_switch_id(8'h00);
    random_phase(40, 8'h00);
    write_switch_id(8'hFF);
    random_phase(40, 8'hFF);
    write_switch_id(8'h3C);
    random_phase(40, 8'h3C);
    s_axis_tvalid <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/sstm_pkg.sv
hw/rtl/sstm_front.sv
hw/rtl/sstm_queue.sv
hw/rtl/sstm_engine.sv
hw/rtl/sorted_software_timer_manager.sv
hw/rtl/sstm_checker.sv
verif/timer_result_checker.sv
verif/sorted_software_timer_manager_tb.sv
